[rtl/sorted_priority_queue_insert_defines.svh]
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_INSERT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_INSERT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spq_pkg.sv]
// Package for the sorted priority queue: sizes, status codes, states, control struct.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int ID_BITS       = 16;
    localparam int PRIORITY_BITS = 32;

    // Port field widths
    localparam int ID_W  = 16;
    localparam int PRI_W = 32;
    localparam int CNT_W = 7;

    localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_INSERTED    = 2'd0,
        ST_NEW_HEAD    = 2'd1,
        ST_NO_PRIORITY = 2'd2,
        ST_FULL        = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CMP,
        S_WRITE_NEW,
        S_DONE
    } state_t;

    // Control from the sequencer to the entry store
    typedef struct packed {
        logic                     we;
        logic [IDX_BITS-1:0]      waddr;
        logic [ID_BITS-1:0]       wid;
        logic [PRIORITY_BITS-1:0] wpri;
        logic [IDX_BITS-1:0]      raddr;
        logic [PRIORITY_BITS-1:0] key;
    } spq_store_ctrl_t;

endpackage

[rtl/spq_store.sv]
// Entry store of the priority queue: one-write, one-read memory with the shared compare unit.
module spq_store
    import spq_pkg::*;
(
    input  logic                     clk,
    input  spq_store_ctrl_t          ctrl,
    output logic [ID_BITS-1:0]       rd_id,
    output logic [PRIORITY_BITS-1:0] rd_pri,
    output logic                     rd_ge
);

    logic [ID_BITS-1:0]       mem_id  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] mem_pri [QUEUE_DEPTH];
    logic [ID_BITS-1:0]       rd_id_reg;
    logic [PRIORITY_BITS-1:0] rd_pri_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem_id[ctrl.waddr]  <= ctrl.wid;
            mem_pri[ctrl.waddr] <= ctrl.wpri;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_id_reg  <= mem_id[ctrl.raddr];
        rd_pri_reg <= mem_pri[ctrl.raddr];
    end

    assign rd_id  = rd_id_reg;
    assign rd_pri = rd_pri_reg;

    // Shared compare: held entry stays ahead when its priority is not lower
    assign rd_ge = (rd_pri_reg >= ctrl.key);

endmodule

[rtl/sorted_priority_queue_insert.sv]
// Top level of the sorted-insertion priority queue (insert side).
// Holds up to QUEUE_DEPTH tasks sorted from highest to lowest priority; equal
// priorities keep arrival order. One insert is a transaction on the input
// channel and gives one result transaction: status, head after the insert and
// entry count. The block takes one transaction at a time. A rejected item
// (missing priority or full store) goes from S_START to S_DONE. A valid insert
// walks from the tail of the list through one memory read port and one
// comparator, moving each lower-priority entry down one slot: each step reads
// in S_READ, then compares and writes in S_CMP; it stops behind a held entry, or
// goes through S_WRITE_NEW as the new head. The next transaction is taken in the
// cycle after the result is loaded into the output register.
module sorted_priority_queue_insert
    import spq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ID_W-1:0]  item_id,
    input  logic [PRI_W-1:0] priority_req,
    input  logic             priority_valid,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       status,
    output logic [ID_W-1:0]  head_id,
    output logic [PRI_W-1:0] head_priority,
    output logic [CNT_W-1:0] entry_count
);

    state_t state_reg, state_next;

    logic [ID_BITS-1:0]       id_reg;
    logic [PRIORITY_BITS-1:0] pri_reg;
    logic                     pval_reg;
    logic [IDX_BITS-1:0]      k_reg, k_next;
    logic [CNT_BITS-1:0]      count_reg, count_next;
    logic [ID_BITS-1:0]       head_id_reg, head_id_next;
    logic [PRIORITY_BITS-1:0] head_pri_reg, head_pri_next;
    status_t                  res_status_reg, res_status_next;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [ID_W-1:0]          out_head_id_reg;
    logic [PRI_W-1:0]         out_head_pri_reg;
    logic [CNT_W-1:0]         out_count_reg;

    spq_store_ctrl_t          ctrl;
    logic [ID_BITS-1:0]       rd_id;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic                     rd_ge;

    logic accept;
    logic is_full;
    logic out_free;
    logic load_out;

    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign out_free = !out_valid_reg || !out_stall;

    spq_store u_store (
        .clk    (clk),
        .ctrl   (ctrl),
        .rd_id  (rd_id),
        .rd_pri (rd_pri),
        .rd_ge  (rd_ge)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_START;
            end
            S_START:
            begin
                if (!pval_reg || is_full)
                    state_next = S_DONE;
                else if (count_reg == '0)
                    state_next = S_WRITE_NEW;
                else
                    state_next = S_READ;
            end
            S_READ:
                state_next = S_CMP;
            S_CMP:
            begin
                if (rd_ge)
                    state_next = S_DONE;
                else if (k_reg == IDX_BITS'(1))
                    state_next = S_WRITE_NEW;
                else
                    state_next = S_READ;
            end
            S_WRITE_NEW:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and store control
    always_comb
    begin
        in_stall   = 1'b1;
        load_out   = 1'b0;
        ctrl.we    = 1'b0;
        ctrl.waddr = k_reg;
        ctrl.wid   = id_reg;
        ctrl.wpri  = pri_reg;
        ctrl.raddr = k_reg - IDX_BITS'(1);
        ctrl.key   = pri_reg;
        case (state_reg)
            S_IDLE:
                in_stall = 1'b0;
            S_CMP:
            begin
                ctrl.we = 1'b1;
                if (!rd_ge)
                begin
                    // move the lower-priority entry one slot toward the tail
                    ctrl.wid  = rd_id;
                    ctrl.wpri = rd_pri;
                end
            end
            S_WRITE_NEW:
                ctrl.we = 1'b1;
            S_DONE:
                load_out = out_free;
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        k_next          = k_reg;
        count_next      = count_reg;
        head_id_next    = head_id_reg;
        head_pri_next   = head_pri_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    k_next = IDX_BITS'(count_reg);
            end
            S_START:
            begin
                if (!pval_reg)
                    res_status_next = ST_NO_PRIORITY;
                else if (is_full)
                    res_status_next = ST_FULL;
            end
            S_CMP:
            begin
                if (rd_ge)
                begin
                    count_next      = count_reg + CNT_BITS'(1);
                    res_status_next = ST_INSERTED;
                end
                else
                    k_next = k_reg - IDX_BITS'(1);
            end
            S_WRITE_NEW:
            begin
                count_next      = count_reg + CNT_BITS'(1);
                head_id_next    = id_reg;
                head_pri_next   = pri_reg;
                res_status_next = ST_NEW_HEAD;
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg   <= ID_BITS'(item_id);
            pri_reg  <= PRIORITY_BITS'(priority_req);
            pval_reg <= priority_valid;
        end
        k_reg          <= k_next;
        head_id_reg    <= head_id_next;
        head_pri_reg   <= head_pri_next;
        res_status_reg <= res_status_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= CNT_W'(count_reg);
            if (count_reg == '0)
            begin
                out_head_id_reg  <= '0;
                out_head_pri_reg <= '0;
            end
            else
            begin
                out_head_id_reg  <= ID_W'(head_id_reg);
                out_head_pri_reg <= PRI_W'(head_pri_reg);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign head_id       = out_head_id_reg;
    assign head_priority = out_head_pri_reg;
    assign entry_count   = out_count_reg;

endmodule

[rtl/spq_checker.sv]
// Port-level checker for the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_insert_defines.svh"

module spq_checker
    import spq_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [ID_W-1:0]  item_id,
    input logic [PRI_W-1:0] priority_req,
    input logic             priority_valid,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       status,
    input logic [ID_W-1:0]  head_id,
    input logic [PRI_W-1:0] head_priority,
    input logic [CNT_W-1:0] entry_count
);

    // A stalled result holds
    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(head_id) && $stable(head_priority) && $stable(entry_count), "stalled result changed")

    // One transaction at a time: busy right after an accept
    `SPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

    // Count never passes the depth
    `SPQ_ASSERT_NOW(a_count_bound, out_valid, entry_count <= CNT_W'(QUEUE_DEPTH), "entry count above depth")

    // Full rejection only at full depth
    `SPQ_ASSERT_NOW(a_full_count, out_valid && (status == ST_FULL), entry_count == CNT_W'(QUEUE_DEPTH), "full status with room left")

    // Empty list shows a zero head
    `SPQ_ASSERT_NOW(a_empty_head, out_valid && (entry_count == '0), (head_id == '0) && (head_priority == '0) && (status != ST_NEW_HEAD) && (status != ST_INSERTED), "empty list with head or insert")

endmodule

bind sorted_priority_queue_insert spq_checker u_spq_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for sorted_priority_queue_insert: directed and random inserts.
module tb_top;
    import spq_pkg::*;

    typedef struct {
        logic [ID_W-1:0]  item_id;
        logic [PRI_W-1:0] priority_req;
        logic             priority_valid;
    } insert_req_t;

    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  head_id;
        logic [PRI_W-1:0] head_priority;
        logic [CNT_W-1:0] entry_count;
    } queue_report_t;

    localparam int RANDOM_ITEMS = 2000;
    // Longest insert walks the whole list, plus margin.
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 16;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_stall;
    logic [ID_W-1:0]  item_id        = '0;
    logic [PRI_W-1:0] priority_req   = '0;
    logic             priority_valid = 1'b0;
    logic             out_valid;
    logic             out_stall      = 1'b0;
    logic [1:0]       status;
    logic [ID_W-1:0]  head_id;
    logic [PRI_W-1:0] head_priority;
    logic [CNT_W-1:0] entry_count;

    // Stimulus and expected results
    insert_req_t   pending_q[$];
    queue_report_t report_q[$];
    int            total_items = 0;
    int            taken_count = 0;
    int            status_seen[4] = '{0, 0, 0, 0};
    bit            failed = 1'b0;
    logic          req_taken = 1'b0;

    // Model of the sorted store
    logic [ID_BITS-1:0]       held_ids [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] held_pris[QUEUE_DEPTH];
    int                       held_entries = 0;

    // Sender burst and receiver stall state
    int burst_left  = 1;
    int gap_left    = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int stall_cycle = 0;

    sorted_priority_queue_insert i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .item_id        (item_id),
        .priority_req   (priority_req),
        .priority_valid (priority_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .head_id        (head_id),
        .head_priority  (head_priority),
        .entry_count    (entry_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Insert one task into the model list and report status, head and count
    function automatic queue_report_t apply_insert(insert_req_t req);
        queue_report_t            rep;
        int                       slot;
        logic [ID_BITS-1:0]       new_id;
        logic [PRIORITY_BITS-1:0] new_pri;
        new_id  = req.item_id[ID_BITS-1:0];
        new_pri = req.priority_req[PRIORITY_BITS-1:0];
        if (!req.priority_valid)
        begin
            rep.status = ST_NO_PRIORITY;
        end
        else if (held_entries >= QUEUE_DEPTH)
        begin
            rep.status = ST_FULL;
        end
        else
        begin
            // new entry goes behind every entry of equal or higher priority
            slot = 0;
            while (slot < held_entries && held_pris[slot] >= new_pri)
                slot++;
            for (int k = held_entries; k > slot; k--)
            begin
                held_ids[k]  = held_ids[k - 1];
                held_pris[k] = held_pris[k - 1];
            end
            held_ids[slot]  = new_id;
            held_pris[slot] = new_pri;
            held_entries++;
            rep.status = (slot == 0) ? ST_NEW_HEAD : ST_INSERTED;
        end
        rep.head_id       = (held_entries > 0) ? ID_W'(held_ids[0]) : '0;
        rep.head_priority = (held_entries > 0) ? PRI_W'(held_pris[0]) : '0;
        rep.entry_count   = CNT_W'(held_entries);
        return rep;
    endfunction

    task automatic push_item(input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
                             input logic valid);
        insert_req_t r;
        r.item_id        = id;
        r.priority_req   = pri;
        r.priority_valid = valid;
        pending_q.push_back(r);
    endtask

    // Driver: bursts of transactions with random gaps, payload held while stalled
    always @(negedge clk)
    begin : drive_proc
        insert_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !req_taken)
        begin
            // stalled: hold payload
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_q.size() > 0)
        begin
            nxt = pending_q.pop_front();
            item_id        <= nxt.item_id;
            priority_req   <= nxt.priority_req;
            priority_valid <= nxt.priority_valid;
            in_valid       <= 1'b1;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // Receiver stall pattern: random stall runs, with a stall mode drawn anew periodically
    always @(negedge clk)
    begin
        stall_cycle++;
        if (stall_cycle % 300 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_mode != 0 && $urandom_range(0, 7) < stall_mode * 2)
        begin
            stall_left = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict on accepted inserts, check accepted results in order
    always @(posedge clk)
    begin : check_proc
        insert_req_t   seen;
        queue_report_t want;
        if (rst_n)
        begin
            req_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                seen.item_id        = item_id;
                seen.priority_req   = priority_req;
                seen.priority_valid = priority_valid;
                report_q.push_back(apply_insert(seen));
                taken_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result transaction with no insert outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    want = report_q.pop_front();
                    status_seen[want.status]++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failed = 1'b1;
                    end
                    if (head_id !== want.head_id)
                    begin
                        $error("head_id: expected %0h, got %0h", want.head_id, head_id);
                        failed = 1'b1;
                    end
                    if (head_priority !== want.head_priority)
                    begin
                        $error("head_priority: expected %0h, got %0h",
                               want.head_priority, head_priority);
                        failed = 1'b1;
                    end
                    if (entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, entry_count);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin : stim_proc
        insert_req_t      r;
        logic [PRI_W-1:0] rising;
        logic [PRI_W-1:0] tie_vals[5];
        tie_vals = '{32'd0, 32'd1, 32'd1000, 32'h8000_0000, 32'hFFFF_FFFF};
        rising   = 32'd2000;

        // missing priority on an empty store reports a zero head
        push_item(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        push_item(16'h0000, 32'h0000_0000, 1'b0);
        // first insert becomes head, then equal to head goes behind it
        push_item(16'h0001, 32'd100, 1'b1);
        push_item(16'h0002, 32'd100, 1'b1);
        push_item(16'h0003, 32'd0, 1'b1);
        push_item(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(16'h0000, 32'hFFFF_FFFF, 1'b1);
        // missing priority on a non-empty store
        push_item(16'hA5A5, 32'h5A5A_5A5A, 1'b0);
        push_item(16'h1234, 32'd50, 1'b1);
        push_item(16'h4321, 32'd0, 1'b1);
        push_item(16'h8000, 32'hFFFF_FFFE, 1'b1);
        push_item(16'h7FFF, 32'd101, 1'b1);

        // random part; the store fills early, then full and missing take over
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            r.item_id        = ID_W'($urandom);
            r.priority_valid = ($urandom_range(0, 4) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2: r.priority_req = $urandom;
                3, 4:    r.priority_req = tie_vals[$urandom_range(0, 4)];
                5:       r.priority_req = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                6, 7:
                begin
                    // climbing priorities: new heads with long walks
                    rising = rising + $urandom_range(1, 5000);
                    r.priority_req = rising;
                end
                default: r.priority_req = $urandom_range(0, 15);
            endcase
            pending_q.push_back(r);
        end
        total_items = pending_q.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (taken_count == total_items);
        wait (report_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (report_q.size() != 0)
        begin
            $error("%0d expected results never arrived", report_q.size());
            failed = 1'b1;
        end

        $display("checked %0d insert transactions: %0d placed behind the head, %0d new heads",
                 total_items, status_seen[ST_INSERTED], status_seen[ST_NEW_HEAD]);
        $display("rejected: %0d with missing priority, %0d with the store full",
                 status_seen[ST_NO_PRIORITY], status_seen[ST_FULL]);
        if (!failed)
        begin
            $display("sorted_priority_queue_insert regression: pass");
        end
        else
        begin
            $display("sorted_priority_queue_insert regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #10000000;
        $display("sorted_priority_queue_insert regression: fail");
        $finish;
    end

endmodule
